// ----- src/cflsp_pkg.sv -----
// Package: types, constants and tables for the crossfade loop sample player.
package cflsp_pkg;

    localparam int SampleAw = 16;
    localparam int SampleDepth = 1 << SampleAw;
    localparam int FracBits = 16;
    localparam int SineAw = 8;
    localparam int SineDepth = 1 << SineAw;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [2:0] REG_LOOP_START   = 3'd1;
    localparam logic [2:0] REG_LOOP_END     = 3'd2;
    localparam logic [2:0] REG_XFADE        = 3'd3;
    localparam logic [2:0] REG_EQUAL_POWER  = 3'd4;
    localparam logic [2:0] REG_SEED         = 3'd5;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        address;
        logic signed [15:0] sample_word;
        logic [31:0]        start_position;
        logic [19:0]        step;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] audio_out;
        logic               fading;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_MAIN, ST_WAIT_MAIN, ST_RD_SEC, ST_WAIT_SEC,
        ST_DIV, ST_MIX_MUL, ST_MIX_SUM, ST_ADV, ST_RAND_MUL, ST_OUT
    } state_t;

    // Quarter sine in Q15, same integer series as the checker's table.
    function automatic logic [15:0] sine_entry(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] sum;
        x = (64'd1686629713 * 64'(idx)) / SineDepth;
        term = x;
        sum = signed'(x);
        for (int k = 1; k <= 7; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - signed'(term);
            else sum = sum + signed'(term);
        end
        if (sum < 0) sum = 0;
        return 16'((64'(sum) + 64'd16384) >> 15);
    endfunction

    function automatic logic [16:0] sine_gain(input logic [SineAw:0] k);
        logic [16:0] g;
        g = 17'd32768;
        for (int i = 0; i < SineDepth; i++) begin
            if (k == (SineAw + 1)'(i)) g = {1'b0, sine_entry(i)};
        end
        return g;
    endfunction

endpackage

// ----- src/cflsp_div.sv -----
// Bit-serial unsigned divider for the fade progress.
module cflsp_div
    import cflsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quot_reg;
    logic [16:0] rem_reg;
    logic [15:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] trial;
    logic [16:0] shifted;

    assign shifted  = {rem_reg[15:0], quot_reg[31]};
    assign trial    = shifted - {1'b0, den_reg};
    assign quotient = quot_reg;
    assign done     = busy_reg && (cnt_reg == 6'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (!trial[16])
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
    end
endmodule

// ----- src/crossfade_loop_sample_player_top.sv -----
// Crossfade loop sample player: top level with sample memory and control sequencer.
// Load, start and idle items go to output; a tick reads and steps the main head, a fade
// onset seeds the second head, and a fading tick mixes both after a 32-step divide of
// the fade progress. One item is in work at a time; the next is taken with the result.
// Reset is asynchronous, active low; it restores register defaults, stops playback
// and clears the heads. The sample memory is not cleared and holds junk until loaded.
module crossfade_loop_sample_player_top
    import cflsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);
    // configuration
    logic [16:0] count_reg;
    logic [15:0] ls_reg, le_reg, len_cfg_reg;
    logic        eqp_reg;
    logic [31:0] lfsr_reg, lfsr_next;

    // play state
    logic [31:0] main_reg, main_next, sec_reg, sec_next;
    logic [15:0] fcnt_reg, fcnt_next;
    logic        fade_reg, fade_next, play_reg, play_next;

    // working registers
    state_t      state_reg, state_next;
    in_item_t    item_reg, item_next;
    logic signed [16:0] o_reg, o_next, i_reg, i_next;
    logic signed [33:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [47:0] prod_reg, prod_next;
    logic        ovalid_reg, ovalid_next;
    out_item_t   odata_reg, odata_next;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_q;
    logic [16:0] p_reg, p_next;
    logic signed [38:0] thr_reg, thr_next;
    logic [31:0] span_reg, span_next;

    // memory
    logic signed [15:0] mem [SampleDepth];
    logic signed [15:0] rd_a_reg, rd_b_reg;
    logic [SampleAw-1:0] rd_addr;
    logic        rd_en;

    // derived config
    logic [16:0] eff_cnt;
    logic [16:0] le_i;
    logic [16:0] cnt_m2;
    logic [15:0] len;
    logic [16:0] len17;
    logic [36:0] fl;
    logic signed [38:0] le_fx, ls_fx, thr, latest;
    logic [31:0] head_sel;
    logic [15:0] ip;
    logic [16:0] fr;
    logic [15:0] idx;
    logic signed [16:0] interp;
    logic signed [33:0] ip_prod;
    logic signed [33:0] ip_rnd;
    logic [31:0] main_adv;
    logic [SineAw:0] kk;
    logic [16:0] g_in, g_out;
    logic signed [34:0] mix;
    logic signed [34:0] mix_rnd;
    logic signed [18:0] mix_sh;
    logic signed [15:0] mix_sat;
    logic [31:0] lfsr_step;
    logic [31:0] sec_rand;

    assign eff_cnt = count_reg[16] ? 17'(SampleDepth) : count_reg;
    assign cnt_m2  = eff_cnt - 17'd2;
    assign len     = (len_cfg_reg == 16'd0) ? 16'd1 : len_cfg_reg;
    assign len17   = {1'b0, len};

    always_comb
    begin
        le_i = {1'b0, le_reg};
        if (eff_cnt < 17'd2 || le_i > cnt_m2) le_i = (eff_cnt < 17'd2) ? 17'h1FFFF : cnt_m2;
        if (eff_cnt < 17'd2) le_i = {1'b0, ls_reg} + 17'd2;
        else if (le_i < {1'b0, ls_reg} + 17'd2) le_i = {1'b0, ls_reg} + 17'd2;
    end

    assign fl     = 37'(item_reg.step) * 37'(len);
    assign le_fx  = signed'({6'd0, le_i, 16'd0});
    assign ls_fx  = signed'({7'd0, ls_reg, 16'd0});
    assign thr    = le_fx - signed'({2'b0, fl});
    assign latest = ((thr_reg - 39'sd131072) < ls_fx) ? ls_fx : (thr_reg - 39'sd131072);

    assign head_sel = (state_reg == ST_RD_SEC || state_reg == ST_WAIT_SEC) ? sec_reg : main_reg;

    // interpolation of the head being read
    always_comb
    begin
        ip = head_sel[31:16];
        fr = {1'b0, head_sel[15:0]};
        if (eff_cnt >= 17'd2 && {1'b0, ip} > cnt_m2)
        begin
            ip = cnt_m2[15:0];
            fr = 17'h10000;
        end
    end
    assign idx     = ip;
    assign ip_prod = signed'({17'd0, fr}) * (34'(rd_b_reg) - 34'(rd_a_reg));
    assign ip_rnd  = (ip_prod + 34'sd32768) >>> 16;
    assign interp  = (eff_cnt < 17'd2) ? 17'sd0 : (17'(rd_a_reg) + 17'(ip_rnd));

    assign main_adv  = main_reg + 32'(item_reg.step);
    assign kk        = p_reg[16:8];
    assign g_in      = sine_gain(kk);
    assign g_out     = sine_gain((SineAw + 1)'(SineDepth) - kk);
    assign mix       = 35'(acc_a_reg) + 35'(acc_b_reg);
    assign mix_rnd   = eqp_reg ? ((mix + 35'sd16384) >>> 15) : ((mix + 35'sd32768) >>> 16);
    assign mix_sh    = 19'(mix_rnd);
    assign mix_sat   = (mix_sh > 19'sd32767) ? 16'sd32767 :
                       (mix_sh < -19'sd32768) ? -16'sd32768 : 16'(mix_sh);
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
    assign sec_rand  = 32'(ls_fx) + 32'(prod_reg >> 16);

    assign in_ready  = (state_reg == ST_IDLE) && !(ovalid_reg && !out_ready);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    cflsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({fcnt_reg, 16'd0}),
        .divisor  (len),
        .done     (div_done),
        .quotient (div_q)
    );

    // sample memory: one write port for loads, two read ports for a head and its next word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_data.mode == MODE_LOAD)
            mem[in_data.address] <= in_data.sample_word;
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr];
            rd_b_reg <= mem[rd_addr + SampleAw'(1)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 17'd65536;
            ls_reg      <= 16'd0;
            le_reg      <= 16'd65533;
            len_cfg_reg <= 16'd1024;
            eqp_reg     <= 1'b0;
            lfsr_reg    <= 32'd1;
            main_reg    <= '0;
            sec_reg     <= '0;
            fcnt_reg    <= '0;
            fade_reg    <= 1'b0;
            play_reg    <= 1'b0;
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            main_reg   <= main_next;
            sec_reg    <= sec_next;
            fcnt_reg   <= fcnt_next;
            fade_reg   <= fade_next;
            play_reg   <= play_next;
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            lfsr_reg   <= lfsr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLE_COUNT: count_reg   <= cfg_data[16:0];
                    REG_LOOP_START:   ls_reg      <= cfg_data[15:0];
                    REG_LOOP_END:     le_reg      <= cfg_data[15:0];
                    REG_XFADE:        len_cfg_reg <= cfg_data[15:0];
                    REG_EQUAL_POWER:  eqp_reg     <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        o_reg     <= o_next;
        i_reg     <= i_next;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        prod_reg  <= prod_next;
        p_reg     <= p_next;
        odata_reg <= odata_next;
        thr_reg   <= thr_next;
        span_reg  <= span_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        main_next   = main_reg;
        sec_next    = sec_reg;
        fcnt_next   = fcnt_reg;
        fade_next   = fade_reg;
        play_next   = play_reg;
        lfsr_next   = lfsr_reg;
        o_next      = o_reg;
        i_next      = i_reg;
        acc_a_next  = acc_a_reg;
        acc_b_next  = acc_b_reg;
        prod_next   = prod_reg;
        p_next      = p_reg;
        odata_next  = odata_reg;
        thr_next    = thr_reg;
        span_next   = span_reg;
        ovalid_next = ovalid_reg && !out_ready;
        div_start   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx[SampleAw-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next  = in_data;
                    odata_next = '0;
                    if (in_data.mode == MODE_START)
                    begin
                        main_next = in_data.start_position;
                        sec_next  = 32'(ls_fx);
                        fcnt_next = '0;
                        fade_next = 1'b0;
                        play_next = 1'b1;
                    end
                    if (in_data.mode == MODE_TICK && play_reg) state_next = ST_RD_MAIN;
                    else state_next = ST_OUT;
                end
            end
            ST_RD_MAIN:
            begin
                rd_en      = 1'b1;
                thr_next   = thr;
                state_next = ST_WAIT_MAIN;
            end
            ST_WAIT_MAIN:
            begin
                o_next    = interp;
                span_next = 32'(latest - ls_fx);
                if (fade_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_RD_SEC;
                end
                else
                begin
                    odata_next.audio_out = 16'(interp);
                    state_next = ST_ADV;
                end
            end
            ST_RD_SEC:
            begin
                rd_en      = 1'b1;
                state_next = ST_WAIT_SEC;
            end
            ST_WAIT_SEC:
            begin
                i_next     = interp;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    p_next     = (div_q > 32'h10000) ? 17'h10000 : div_q[16:0];
                    state_next = ST_MIX_MUL;
                end
            end
            ST_MIX_MUL:
            begin
                if (eqp_reg)
                begin
                    acc_a_next = 34'(o_reg) * signed'({17'd0, g_out});
                    acc_b_next = 34'(i_reg) * signed'({17'd0, g_in});
                end
                else
                begin
                    acc_a_next = 34'(o_reg) * signed'({17'd0, 17'h10000 - p_reg});
                    acc_b_next = 34'(i_reg) * signed'({17'd0, p_reg});
                end
                state_next = ST_MIX_SUM;
            end
            ST_MIX_SUM:
            begin
                odata_next.audio_out = mix_sat;
                odata_next.fading    = 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                main_next  = main_adv;
                state_next = ST_OUT;
                if (fade_reg)
                begin
                    sec_next  = sec_reg + 32'(item_reg.step);
                    fcnt_next = fcnt_reg + 16'd1;
                    if (17'(fcnt_reg) + 17'd1 >= len17)
                    begin
                        main_next = sec_reg + 32'(item_reg.step);
                        fade_next = 1'b0;
                        fcnt_next = '0;
                    end
                end
                else if (signed'({7'd0, main_adv}) >= thr_reg)
                begin
                    fade_next  = 1'b1;
                    fcnt_next  = '0;
                    lfsr_next  = lfsr_step;
                    prod_next  = 48'(lfsr_step[31:16]) * 48'(span_reg);
                    state_next = ST_RAND_MUL;
                end
            end
            ST_RAND_MUL:
            begin
                sec_next   = sec_rand;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // seed write reloads the generator
        if (cfg_we && cfg_index == REG_SEED)
            lfsr_next = (cfg_data == 32'd0) ? 32'd1 : cfg_data;
    end
endmodule

// ----- test/cflsp_checker.sv -----
// Checker for the crossfade loop sample player: predicts each result and compares.
`timescale 1ns / 100ps

module cflsp_checker
    import cflsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    logic signed [15:0] sample_mem [SampleDepth];
    logic [15:0] sine_q15 [SineDepth];

    logic [16:0] count_reg;
    logic [15:0] loop_first;
    logic [15:0] loop_last;
    logic [15:0] fade_len;
    logic        equal_pow;
    logic [31:0] lfsr;

    logic [31:0] main_pos;
    logic [31:0] second_pos;
    longint      fade_ticks;
    logic        fade_on;
    logic        running;

    out_item_t   expected_q [$];
    out_item_t   predicted;
    out_item_t   want;

    // Quarter sine in Q15 from an 8-term Taylor series in Q30.
    function automatic logic [15:0] quarter_sine(input int idx);
        longint unsigned x;
        longint unsigned term;
        longint acc;
        x = (64'd1686629713 * 64'(idx)) / SineDepth;
        term = x;
        acc = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        return 16'((acc + 16384) >>> 15);
    endfunction

    initial begin
        for (int i = 0; i < SineDepth; i++) sine_q15[i] = quarter_sine(i);
    end

    function automatic longint round_shift(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint gain_of(input longint k);
        if (k >= SineDepth) return 32768;
        return longint'(sine_q15[k]);
    endfunction

    function automatic longint usable_count();
        return (count_reg > SampleDepth) ? SampleDepth : longint'(count_reg);
    endfunction

    function automatic longint sample_at(input logic [31:0] pos);
        longint cnt;
        longint ip;
        longint fr;
        longint a;
        longint b;
        cnt = usable_count();
        ip = longint'(pos[31:16]);
        fr = longint'(pos[15:0]);
        if (cnt < 2) return 0;
        // past the data: hold the last sample
        if (ip > cnt - 2) begin
            ip = cnt - 2;
            fr = longint'(1) <<< FracBits;
        end
        a = sample_mem[ip];
        b = sample_mem[ip + 1];
        return a + round_shift(fr * (b - a), FracBits);
    endfunction

    task automatic predict_item(input in_item_t it, output out_item_t res);
        longint len;
        longint one;
        longint ls;
        longint le;
        longint cnt;
        longint o;
        longint s2;
        longint p;
        longint k;
        longint mix;
        longint fl;
        longint latest;
        longint stp;
        longint unsigned r;
        len = (fade_len == 0) ? 1 : longint'(fade_len);
        one = longint'(1) <<< FracBits;
        ls = longint'(loop_first) <<< FracBits;
        cnt = usable_count();
        le = longint'(loop_last);
        if (le > cnt - 2) le = cnt - 2;
        if (le < longint'(loop_first) + 2) le = longint'(loop_first) + 2;
        le = le <<< FracBits;
        mix = 0;
        res.fading = 1'b0;
        case (it.mode)
            MODE_LOAD: sample_mem[it.address] = it.sample_word;
            MODE_START:
            begin
                main_pos = it.start_position;
                second_pos = ls[31:0];
                fade_ticks = 0;
                fade_on = 1'b0;
                running = 1'b1;
            end
            MODE_TICK:
            begin
                if (running)
                begin
                    stp = longint'(it.step);
                    o = sample_at(main_pos);
                    res.fading = fade_on;
                    if (!fade_on) mix = o;
                    else
                    begin
                        s2 = sample_at(second_pos);
                        p = (fade_ticks <<< FracBits) / len;
                        if (p > one) p = one;
                        if (equal_pow)
                        begin
                            k = (p * SineDepth) >>> FracBits;
                            mix = round_shift(o * gain_of(SineDepth - k) + s2 * gain_of(k), 15);
                            if (mix > 32767) mix = 32767;
                            if (mix < -32768) mix = -32768;
                        end
                        else mix = round_shift(o * (one - p) + s2 * p, FracBits);
                    end
                    main_pos = 32'(longint'(main_pos) + stp);
                    if (fade_on)
                    begin
                        second_pos = 32'(longint'(second_pos) + stp);
                        fade_ticks++;
                        // fade over: main head jumps to the second head
                        if (fade_ticks >= len)
                        begin
                            main_pos = second_pos;
                            fade_on = 1'b0;
                            fade_ticks = 0;
                        end
                    end
                    else
                    begin
                        fl = stp * len;
                        if (longint'(main_pos) >= le - fl)
                        begin
                            latest = le - fl - 2 * one;
                            if (latest < ls) latest = ls;
                            fade_on = 1'b1;
                            fade_ticks = 0;
                            lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 32'd0);
                            r = longint'(lfsr[31:16]);
                            second_pos = 32'(ls + longint'((r * longint'(latest - ls)) >> 16));
                        end
                    end
                end
            end
            default: ;
        endcase
        res.audio_out = mix[15:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg = 17'd65536;
            loop_first = 16'd0;
            loop_last = 16'd65533;
            fade_len = 16'd1024;
            equal_pow = 1'b0;
            lfsr = 32'd1;
            main_pos = '0;
            second_pos = '0;
            fade_ticks = 0;
            fade_on = 1'b0;
            running = 1'b0;
            expected_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLE_COUNT: count_reg = cfg_data[16:0];
                    REG_LOOP_START:   loop_first = cfg_data[15:0];
                    REG_LOOP_END:     loop_last = cfg_data[15:0];
                    REG_XFADE:        fade_len = cfg_data[15:0];
                    REG_EQUAL_POWER:  equal_pow = cfg_data[0];
                    REG_SEED:         lfsr = (cfg_data == 0) ? 32'd1 : cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_item(in_data, predicted);
                expected_q.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item audio_out=%0d fading=%0b",
                             $time, out_data.audio_out, out_data.fading);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.audio_out !== want.audio_out)
                    begin
                        errors++;
                        $display("%0t: audio_out expected %0d actual %0d",
                                 $time, want.audio_out, out_data.audio_out);
                    end
                    if (out_data.fading !== want.fading)
                    begin
                        errors++;
                        $display("%0t: fading expected %0b actual %0b",
                                 $time, want.fading, out_data.fading);
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ----- test/crossfade_loop_sample_player_top_tb.sv -----
// Testbench top for the crossfade loop sample player: stimulus, idling and verdict.
`timescale 1ns / 100ps

module crossfade_loop_sample_player_top_tb;
    import cflsp_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int LoadedWords = 256;
    localparam int SettleCycles = 60;
    localparam int HoldCycles = 400;
    localparam longint CycleLimit = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int     errors;
    int     pending;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     hold_left = 0;
    bit     hold_req = 1'b0;
    int     cur_count = 2;
    longint cycles = 0;

    crossfade_loop_sample_player_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cflsp_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left <= HoldCycles;
            out_ready <= 1'b0;
        end
        else out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic push_item(input in_item_t it);
        logic got;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            got = in_ready;
            @(posedge clk);
        end while (!got);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // drain the block, then write every register
    task automatic configure(input int cnt, input int ls, input int le, input int xf,
                             input int eq, input logic [31:0] seed);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SettleCycles) @(posedge clk);
        cfg_write(REG_SAMPLE_COUNT, 32'(cnt));
        cfg_write(REG_LOOP_START, 32'(ls));
        cfg_write(REG_LOOP_END, 32'(le));
        cfg_write(REG_XFADE, 32'(xf));
        cfg_write(REG_EQUAL_POWER, 32'(eq));
        cfg_write(REG_SEED, seed);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_count = cnt;
    endtask

    function automatic in_item_t make_item(input logic [1:0] mode, input logic [15:0] addr,
                                           input logic [15:0] word, input logic [31:0] pos,
                                           input logic [19:0] stp);
        in_item_t it;
        it.mode = mode;
        it.address = addr;
        it.sample_word = word;
        it.start_position = pos;
        it.step = stp;
        return it;
    endfunction

    // mostly ticks with modest steps; most starts land in or just past the stored data
    function automatic in_item_t random_item();
        in_item_t it;
        int sel;
        it = make_item(MODE_TICK, 16'($urandom), 16'($urandom), $urandom, 20'($urandom));
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            if ($urandom_range(9) != 0) it.step = 20'($urandom_range(0, 'h30000));
        end
        else if (sel < 80)
        begin
            it.mode = MODE_START;
            if ($urandom_range(9) != 0)
                it.start_position = {16'($urandom_range(0, cur_count)), 16'($urandom)};
        end
        else if (sel < 95)
        begin
            it.mode = MODE_LOAD;
            if ($urandom_range(3) != 0) it.address = 16'($urandom_range(0, LoadedWords - 1));
        end
        else it.mode = MODE_UNUSED;
        return it;
    endfunction

    initial
    begin
        send_idle = 25;
        recv_idle = 60;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full store size, nothing playing yet
        configure(65536, 0, 65533, 1024, 0, 32'd1);
        push_item(make_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF, '1, '1));
        push_item(make_item(MODE_TICK, '0, '0, '0, 20'hFFFFF));
        push_item(make_item(MODE_LOAD, 16'hFFFF, 16'h7FFF, '0, '0));
        for (int i = 0; i < LoadedWords; i++)
            push_item(make_item(MODE_LOAD, 16'(i),
                                (i == 0) ? 16'h8000 : (i == 1) ? 16'h7FFF : 16'($urandom),
                                $urandom, 20'($urandom)));

        configure(LoadedWords, 0, 200, 1, 0, 32'd1);
        push_item(make_item(MODE_START, '0, '0, '0, '0));
        push_item(make_item(MODE_TICK, '0, '0, '0, '0));
        push_item(make_item(MODE_TICK, '0, '0, '0, 20'h10000));
        push_item(make_item(MODE_TICK, '0, '0, '0, 20'hFFFFF));
        push_item(make_item(MODE_TICK, '0, '0, '0, 20'hFFFFF));
        // head past the data, then wrap around zero
        push_item(make_item(MODE_START, '0, '0, 32'hFFFF_FFFF, '0));
        push_item(make_item(MODE_TICK, '0, '0, '0, 20'hFFFFF));
        push_item(make_item(MODE_TICK, '0, '0, '0, 20'h00001));
        push_item(make_item(MODE_START, '0, '0, {16'd100, 16'hFFFF}, '0));
        push_item(make_item(MODE_TICK, '0, '0, '0, 20'h08000));

        configure(LoadedWords, 10, 50, 4, 1, 32'hFFFF_FFFF);
        push_item(make_item(MODE_START, '0, '0, {16'd10, 16'd0}, '0));
        repeat (10) push_item(make_item(MODE_TICK, '0, '0, '0, 20'h18000));

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 25 : (ph < 4) ? 60 : 0;
            recv_idle = (ph < 2) ? 60 : (ph < 4) ? 25 : 0;
            case (ph)
                0: configure(2, 0, 65535, 1, 0, $urandom | 32'd1);
                1: configure(LoadedWords, 65535, 0, 65535, 1, 32'd1);
                default: configure($urandom_range(2, LoadedWords), $urandom_range(0, 255),
                                   ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 255),
                                   $urandom_range(1, 8), $urandom_range(0, 1),
                                   $urandom | 32'd1);
            endcase
            push_item(make_item(MODE_START, '0, '0,
                                {16'($urandom_range(0, cur_count)), 16'($urandom)}, '0));
            for (int n = 0; n < 65; n++)
            begin
                if (ph == 2 && n == 10) hold_req = 1'b1;
                if (ph == 3 && n == 30)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait (pending == 0);
                    @(posedge clk);
                end
                push_item(random_item());
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SettleCycles) @(posedge clk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
